### design/rdg_pkg.sv
package rdg_pkg;

	localparam int BOARD_CELLS = 81;
	localparam int DIGITS_PER_DRAW = 7;
	localparam int POS_W = 7;
	localparam int CNT_W = 3;
	localparam int DIGIT_SHIFT = 9;

	typedef logic [63:0] word_t;
	typedef logic [POS_W-1:0] pos_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef struct packed {
		word_t w0;
		word_t w1;
		word_t w2;
		word_t w3;
	} gen_state_t;

	localparam word_t SEED_W0 = 64'h180e_c6d3_3cfd_0aba;
	localparam word_t SEED_W1 = 64'hd5a6_1266_f0c9_392c;
	localparam word_t SEED_W2 = 64'ha958_2618_e03f_c9aa;
	localparam word_t SEED_W3 = 64'h39ab_dc45_29b1_661c;

	localparam pos_t LAST_POS = POS_W'(BOARD_CELLS - 1);
	localparam pos_t BOARD_END = POS_W'(BOARD_CELLS);
	localparam cnt_t MAX_CNT = CNT_W'(DIGITS_PER_DRAW);

endpackage

### design/rdg_xoshiro_step.sv
module rdg_xoshiro_step (
	input  rdg_pkg::gen_state_t cur,
	output rdg_pkg::gen_state_t nxt,
	output rdg_pkg::word_t      result
);
	import rdg_pkg::*;

	word_t sum03;
	word_t sh;
	word_t t2;
	word_t t3;

	always_comb begin
		sum03  = cur.w0 + cur.w3;
		result = {sum03[40:0], sum03[63:41]} + cur.w0;
		sh     = {cur.w1[46:0], 17'd0};
		t2     = cur.w2 ^ cur.w0;
		t3     = cur.w3 ^ cur.w1;
		nxt.w1 = cur.w1 ^ t2;
		nxt.w0 = cur.w0 ^ t3;
		nxt.w2 = t2 ^ sh;
		nxt.w3 = {t3[18:0], t3[63:19]};
	end

endmodule

### design/random_digit_generator_core.sv
// Each accepted draw advances the generator in the cycle it is accepted.
// The first digit appears in the cycle after acceptance; digits then leave one per cycle while out_stall is low.
// A draw has seven digits, or fewer at a board end.
// The next draw can be accepted in the cycle its predecessor's last digit is taken.
// Reset loads the fixed seed words, clears the tweak and the board position.
module random_digit_generator_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  rdg_pkg::word_t     seed_tweak,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               reseed,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [3:0]         digit,
	output logic               last_of_draw,
	output logic               last_of_board
);
	import rdg_pkg::*;

	word_t      tweak_q;
	gen_state_t gen_q;
	pos_t       cell_pos_q;

	logic       valid_s1;
	word_t      word_s1;
	pos_t       pos_s1;
	cnt_t       cnt_s1;

	gen_state_t gen_base;
	gen_state_t gen_next;
	word_t      gen_out;
	pos_t       pos_start;
	pos_t       remain;
	cnt_t       count;
	pos_t       pos_sum;
	logic       in_acc;
	logic       out_acc;
	logic [35:0] prod;

	assign cfg_ready = 1'b1;

	always_comb begin
		if (reseed) begin
			gen_base.w0 = SEED_W0 ^ tweak_q;
			gen_base.w1 = SEED_W1;
			gen_base.w2 = SEED_W2;
			gen_base.w3 = SEED_W3;
		end else begin
			gen_base = gen_q;
		end
	end

	rdg_xoshiro_step u_step (
		.cur    (gen_base),
		.nxt    (gen_next),
		.result (gen_out)
	);

	always_comb begin
		pos_start = (cell_pos_q >= BOARD_END) ? '0 : cell_pos_q;
		remain    = BOARD_END - pos_start;
		count     = (remain < POS_W'(DIGITS_PER_DRAW)) ? remain[CNT_W-1:0] : MAX_CNT;
		pos_sum   = pos_start + POS_W'(count);
	end

	assign out_valid = valid_s1;
	assign out_acc   = valid_s1 && !out_stall;
	assign in_stall  = valid_s1 && !(out_acc && cnt_s1 == cnt_t'(1));
	assign in_acc    = in_valid && !in_stall;

	assign prod          = {4'd0, word_s1[31:0]} * 36'd9;
	assign digit         = prod[35:32];
	assign last_of_draw  = (cnt_s1 == cnt_t'(1));
	assign last_of_board = (pos_s1 == LAST_POS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tweak_q    <= '0;
			gen_q      <= '{SEED_W0, SEED_W1, SEED_W2, SEED_W3};
			cell_pos_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				tweak_q <= seed_tweak;
			end
			if (in_acc) begin
				gen_q      <= gen_next;
				cell_pos_q <= (pos_sum == BOARD_END) ? '0 : pos_sum;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			cnt_s1   <= '0;
		end else begin
			if (in_acc) begin
				valid_s1 <= 1'b1;
				cnt_s1   <= count;
			end else if (out_acc) begin
				valid_s1 <= (cnt_s1 != cnt_t'(1));
				cnt_s1   <= cnt_s1 - cnt_t'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			word_s1 <= gen_out;
			pos_s1  <= pos_start;
		end else if (out_acc) begin
			word_s1 <= word_s1 >> DIGIT_SHIFT;
			pos_s1  <= (pos_s1 == LAST_POS) ? '0 : pos_s1 + pos_t'(1);
		end
	end

	a_cnt_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> cnt_s1 != '0)
		else $error("digit count empty while a draw is pending");

	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> digit <= 4'd8)
		else $error("digit out of range");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		cell_pos_q < BOARD_END)
		else $error("board position out of range");

	a_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && valid_s1) |-> (out_acc && last_of_draw))
		else $error("new draw accepted before previous draw finished");

	a_board_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && last_of_board) |-> last_of_draw)
		else $error("board end digit is not the last of its draw");

endmodule
